@@ rtl/lpmd_pkg.sv @@
// ----------------------------------------------------------------------------
// lpmd_pkg
// Shared word types and constants for the length-prefixed message deframer.
// ----------------------------------------------------------------------------
package lpmd_pkg;

    localparam logic [31:0] NEED_UNKNOWN = 32'hffff_ffff;
    localparam int          LENGTH_BYTES = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_last;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_header;
        logic        message_first;
        logic        message_last;
        logic [31:0] payload_length;
        logic [31:0] bytes_needed;
        logic        chunk_done;
    } t_out;

endpackage

@@ rtl/length_prefixed_message_deframer_unit.sv @@
// bytes are tagged combinationally and registered in the queue before the output
// throughput: one byte per cycle unless the queue is full and the output stalls
// a QUEUE_DEPTH-word queue keeps the input flowing until an output stall fills it
// reset: synchronous, active low; clears the framing state and empties the queue
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer_unit
// Splits a byte stream into length-prefixed messages and tags every byte.
// ----------------------------------------------------------------------------
module length_prefixed_message_deframer_unit #(
    parameter int HEADER_BYTES  = 8,
    parameter int LENGTH_OFFSET = 4,
    parameter int QUEUE_DEPTH   = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  lpmd_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output lpmd_pkg::t_out o_data
);
    import lpmd_pkg::*;

    logic q_valid, q_ready;
    t_out q_data;

    lpmd_front #(
        .HEADER_BYTES (HEADER_BYTES),
        .LENGTH_OFFSET(LENGTH_OFFSET)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(q_valid),
        .i_ready(q_ready),
        .o_data (q_data)
    );

    lpmd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .o_ready(q_ready),
        .i_data (q_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

endmodule

@@ rtl/lpmd_front.sv @@
// ----------------------------------------------------------------------------
// lpmd_front
// Tracks the framing state and tags each incoming byte with its place.
// ----------------------------------------------------------------------------
module lpmd_front #(
    parameter int HEADER_BYTES  = 8,
    parameter int LENGTH_OFFSET = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  lpmd_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output lpmd_pkg::t_out o_data
);
    import lpmd_pkg::*;

    localparam int CW = (HEADER_BYTES > 2) ? $clog2(HEADER_BYTES) : 1;

    logic          r_in_payload, n_in_payload;
    logic [CW-1:0] r_hdr_cnt, n_hdr_cnt;
    logic [31:0]   r_len_acc, n_len_acc;
    logic [31:0]   r_remain, n_remain;

    logic          accept;
    logic [31:0]   pos_ext;
    logic [31:0]   acc_base;
    logic [31:0]   rem_dec;

    assign o_valid = i_valid;
    assign o_ready = i_ready;
    assign accept  = i_valid && i_ready;
    assign pos_ext = 32'(r_hdr_cnt);
    assign rem_dec = r_remain - 32'd1;

    always_comb begin
        n_in_payload = r_in_payload;
        n_hdr_cnt    = r_hdr_cnt;
        n_len_acc    = r_len_acc;
        n_remain     = r_remain;
        acc_base     = r_len_acc;

        o_data.out_byte       = i_data.data_byte;
        o_data.chunk_done     = i_data.chunk_last;
        o_data.is_header      = 1'b0;
        o_data.message_first  = 1'b0;
        o_data.message_last   = 1'b0;
        o_data.payload_length = 32'd0;
        o_data.bytes_needed   = NEED_UNKNOWN;

        if (!r_in_payload) begin
            o_data.is_header = 1'b1;
            if (r_hdr_cnt == '0) begin
                o_data.message_first = 1'b1;
                acc_base             = 32'd0;
            end
            // length bytes arrive most significant first
            if (pos_ext >= 32'(LENGTH_OFFSET) &&
                pos_ext < 32'(LENGTH_OFFSET + LENGTH_BYTES)) begin
                n_len_acc = {acc_base[23:0], i_data.data_byte};
            end else begin
                n_len_acc = acc_base;
            end
            if (pos_ext == 32'(HEADER_BYTES - 1)) begin
                n_hdr_cnt             = '0;
                o_data.payload_length = n_len_acc;
                if (n_len_acc == 32'd0) begin
                    o_data.message_last = 1'b1;
                    o_data.bytes_needed = 32'd0;
                end else begin
                    n_in_payload        = 1'b1;
                    n_remain            = n_len_acc;
                    o_data.bytes_needed = n_len_acc;
                end
            end else begin
                n_hdr_cnt = r_hdr_cnt + CW'(1);
            end
        end else begin
            n_remain              = rem_dec;
            o_data.payload_length = r_len_acc;
            o_data.bytes_needed   = rem_dec;
            if (rem_dec == 32'd0) begin
                o_data.message_last = 1'b1;
                n_in_payload        = 1'b0;
                n_hdr_cnt           = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_hdr_cnt    <= '0;
            r_len_acc    <= 32'd0;
            r_remain     <= 32'd0;
        end else if (accept) begin
            r_in_payload <= n_in_payload;
            r_hdr_cnt    <= n_hdr_cnt;
            r_len_acc    <= n_len_acc;
            r_remain     <= n_remain;
        end
    end

endmodule

@@ rtl/lpmd_queue.sv @@
// ----------------------------------------------------------------------------
// lpmd_queue
// Small word queue between the framing front and the output side.
// ----------------------------------------------------------------------------
module lpmd_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  lpmd_pkg::t_out i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output lpmd_pkg::t_out o_data
);
    import lpmd_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_out          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    logic push, pop;

    assign o_valid = (r_count != '0);
    // a pop in the same cycle frees a slot
    assign o_ready = (r_count != CW'(DEPTH)) || i_ready;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

@@ rtl/lpmd_checker.sv @@
// ----------------------------------------------------------------------------
// lpmd_checker
// Port-level checks on the deframer output, bound to the top level.
// ----------------------------------------------------------------------------
module lpmd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_valid,
    input logic           i_ready,
    input lpmd_pkg::t_out o_data
);
    import lpmd_pkg::*;

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word valid right after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output word dropped while stalled");

    a_first_is_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.message_first |-> o_data.is_header)
        else $error("message start on a payload word");

    // payload words always carry a decoded, nonzero length
    a_payload_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.is_header |->
            o_data.bytes_needed != NEED_UNKNOWN && o_data.payload_length != 32'd0)
        else $error("payload word without a decoded length");

    a_last_needs_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.message_last |-> o_data.bytes_needed == 32'd0)
        else $error("message end with bytes still needed");

endmodule

bind length_prefixed_message_deframer_unit lpmd_checker u_lpmd_checker (.*);
